>>> src/task_mask_time_histogram_assert.svh
// Assertion macros used by the checker file.
`ifndef TASK_MASK_TIME_HISTOGRAM_ASSERT_SVH
`define TASK_MASK_TIME_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TMTH_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("task_mask_time_histogram: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TMTH_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("task_mask_time_histogram: assertion failed");

`endif

>>> src/tmth_pkg.sv
package tmth_pkg;

   // Fixed field widths
   localparam int TICK_W      = 32;
   localparam int MASK_W      = 4;
   localparam int OP_W        = 2;
   localparam int TASK_W      = 2;
   localparam int BIN_IDX_W   = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   // A report run never carries more than this many items
   localparam int REPORT_MAX  = 16;

   // Operation codes of a request item
   typedef enum logic [OP_W-1:0] {
      OP_MARK   = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMER_PERIOD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRAP_TASK    = 1'b1;

   // Command broadcast to every cell of the bin chain
   typedef struct packed {
      logic add_en;
      logic shift_en;
      logic load_en;
   } cell_ctrl_type;

endpackage

>>> src/tmth_channel_if.sv
// Request channel: one operation per item.
interface tmth_req_if;
   logic                       valid;
   logic                       ready;
   logic [tmth_pkg::OP_W-1:0]   operation;
   logic [tmth_pkg::TASK_W-1:0] task_req;
   logic [tmth_pkg::TICK_W-1:0] timer_count;

   modport source (output valid, operation, task_req, timer_count, input ready);
   modport sink   (input valid, operation, task_req, timer_count, output ready);
endinterface

// Response channel: one bin per item.
interface tmth_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tmth_pkg::BIN_IDX_W-1:0] bin_index;
   logic [tmth_pkg::TICK_W-1:0]    bin_ticks;
   logic                          last;

   modport source (output valid, bin_index, bin_ticks, last, input ready);
   modport sink   (input valid, bin_index, bin_ticks, last, output ready);
endinterface

>>> src/tmth_cell.sv
module tmth_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  tmth_pkg::cell_ctrl_type     ctrl,
   input  logic                        select,
   input  logic [tmth_pkg::TICK_W-1:0] addend,
   input  logic [tmth_pkg::TICK_W-1:0] load_value,
   input  logic [tmth_pkg::TICK_W-1:0] next_value,
   output logic [tmth_pkg::TICK_W-1:0] value
);

   logic [tmth_pkg::TICK_W-1:0] value_ff;
   logic [tmth_pkg::TICK_W-1:0] value_in;

   // Shift toward the head, or accumulate / load when this bin is selected
   always_comb begin
      value_in = value_ff;
      if (ctrl.shift_en) begin
         value_in = next_value;
      end else if (select && ctrl.add_en) begin
         value_in = value_ff + addend;
      end else if (select && ctrl.load_en) begin
         value_in = load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

>>> src/tmth_chain.sv
module tmth_chain #(
   parameter int CELL_COUNT = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tmth_pkg::cell_ctrl_type         ctrl,
   input  logic [$clog2(CELL_COUNT)-1:0]   bin_select,
   input  logic [tmth_pkg::TICK_W-1:0]     addend,
   input  logic [tmth_pkg::TICK_W-1:0]     load_value,
   output logic [tmth_pkg::TICK_W-1:0]     head_value
);

   localparam int SEL_W = $clog2(CELL_COUNT);

   logic [tmth_pkg::TICK_W-1:0] cell_value [CELL_COUNT];
   logic [tmth_pkg::TICK_W-1:0] cell_next  [CELL_COUNT];

   // Row of bins; each hands its value to the one below on a shift, zero enters at the tail
   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      if (i == CELL_COUNT - 1) begin : g_tail
         assign cell_next[i] = '0;
      end else begin : g_body
         assign cell_next[i] = cell_value[i+1];
      end

      tmth_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .select     (bin_select == SEL_W'(i)),
         .addend     (addend),
         .load_value (load_value),
         .next_value (cell_next[i]),
         .value      (cell_value[i])
      );
   end

   assign head_value = cell_value[0];

endmodule

>>> src/task_mask_time_histogram.sv
// Load profiler: keeps a 4-bit mask of active tasks and a row of tick bins indexed by that
// mask. Operation 0 sets bit task_req in the mask, 1 clears the mask, 2 takes a timer
// sample; code 3 is ignored. A sample adds the ticks since the previous nonzero sample to the
// bin of the current mask (mask modulo BIN_COUNT). When the count went backwards the wrap
// task bit is set first, the bin gets timer_period minus the previous count, then the bins
// stream out one item each, bin 0 first, with last set on bin BIN_COUNT-1 (at most 16 items,
// so last never shows when BIN_COUNT exceeds 16); the bins are cleared and the current bin
// restarts at the new count. One item is in work at a time: a mark or clear uses EXEC only,
// a sample after a nonzero one also ADD, a wrapping sample ADD, REPORT and LOAD; in REPORT
// the chain shifts one bin per cycle into the output register while that is free.
// Registers: index 0 timer_period, index 1 wrap_task.
module task_mask_time_histogram #(
   parameter int BIN_COUNT   = 16,
   parameter int TIMER_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   tmth_req_if.sink                         req,
   tmth_rsp_if.source                       rsp,
   input  logic                             csr_write_enable,
   input  logic [tmth_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tmth_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CELL_COUNT = (BIN_COUNT < tmth_pkg::REPORT_MAX) ? BIN_COUNT
                                                                : tmth_pkg::REPORT_MAX;
   localparam int SEL_W      = $clog2(CELL_COUNT);
   localparam int SAMPLE_W   = (TIMER_WIDTH < tmth_pkg::TICK_W) ? TIMER_WIDTH
                                                                : tmth_pkg::TICK_W;
   localparam bit LAST_ON    = (BIN_COUNT <= tmth_pkg::REPORT_MAX);
   localparam int MASK_W     = tmth_pkg::MASK_W;
   localparam int TICK_W     = tmth_pkg::TICK_W;

   localparam logic [TICK_W-1:0] PERIOD_RESET = TICK_W'(60000000);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_ADD    = 5'b00100,
      ST_REPORT = 5'b01000,
      ST_LOAD   = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [tmth_pkg::OP_W-1:0]   op_ff, op_in;
   logic [tmth_pkg::TASK_W-1:0] task_ff, task_in;
   logic [SAMPLE_W-1:0]         now_ff, now_in;
   logic [SAMPLE_W-1:0]         prev_ff, prev_in;
   logic [MASK_W-1:0]           mask_ff, mask_in;
   logic [TICK_W-1:0]           addend_ff, addend_in;
   logic                        wrap_ff, wrap_in;
   logic [SEL_W-1:0]            count_ff, count_in;
   logic [TICK_W-1:0]           period_ff, period_in;
   logic [tmth_pkg::TASK_W-1:0] wrap_task_ff, wrap_task_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tmth_pkg::BIN_IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [TICK_W-1:0]           rsp_ticks_ff, rsp_ticks_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        accept;
   logic                        out_free;
   logic                        issue;
   logic                        wrap_now;
   logic [SAMPLE_W-1:0]         diff;
   logic [TICK_W-1:0]           rest;
   logic [MASK_W-1:0]           bin_rem;
   logic [SEL_W-1:0]            bin_select;
   logic [TICK_W-1:0]           head_value;
   tmth_pkg::cell_ctrl_type     cell_ctrl;

   assign accept   = req.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign issue    = (state_ff == ST_REPORT) && out_free;

   // Elapsed ticks, plain and across a wrap
   assign wrap_now = now_ff < prev_ff;
   assign diff     = now_ff - prev_ff;
   assign rest     = period_ff - TICK_W'(prev_ff);

   // Reduce the mask to a bin by repeated subtraction
   always_comb begin
      bin_rem = mask_ff;
      for (int k = 0; k < 8; k++) begin
         if (int'(bin_rem) >= BIN_COUNT) begin
            bin_rem = bin_rem - MASK_W'(BIN_COUNT);
         end
      end
   end
   assign bin_select = SEL_W'(bin_rem);

   // Broadcast command to the chain
   always_comb begin
      cell_ctrl.add_en   = (state_ff == ST_ADD);
      cell_ctrl.shift_en = issue;
      cell_ctrl.load_en  = (state_ff == ST_LOAD);
   end

   tmth_chain #(
      .CELL_COUNT (CELL_COUNT)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (cell_ctrl),
      .bin_select (bin_select),
      .addend     (addend_ff),
      .load_value (TICK_W'(now_ff)),
      .head_value (head_value)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      task_in      = task_ff;
      now_in       = now_ff;
      prev_in      = prev_ff;
      mask_in      = mask_ff;
      addend_in    = addend_ff;
      wrap_in      = wrap_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_index_in = rsp_index_ff;
      rsp_ticks_in = rsp_ticks_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            // Latch the item
            if (accept) begin
               op_in    = req.operation;
               task_in  = req.task_req;
               now_in   = req.timer_count[SAMPLE_W-1:0];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (op_ff)
               tmth_pkg::OP_MARK: begin
                  mask_in = mask_ff | (MASK_W'(1) << task_ff);
               end
               tmth_pkg::OP_CLEAR: begin
                  mask_in = '0;
               end
               tmth_pkg::OP_SAMPLE: begin
                  prev_in = now_ff;
                  if (prev_ff != '0) begin
                     wrap_in  = wrap_now;
                     state_in = ST_ADD;
                     if (wrap_now) begin
                        addend_in = rest;
                        mask_in   = mask_ff | (MASK_W'(1) << wrap_task_ff);
                     end else begin
                        addend_in = TICK_W'(diff);
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_ADD: begin
            // Chain accumulates this cycle
            count_in = '0;
            state_in = wrap_ff ? ST_REPORT : ST_IDLE;
         end
         ST_REPORT: begin
            // Move the head bin into the output register
            if (issue) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = tmth_pkg::BIN_IDX_W'(count_ff);
               rsp_ticks_in = head_value;
               rsp_last_in  = LAST_ON && (count_ff == SEL_W'(CELL_COUNT - 1));
               count_in     = count_ff + SEL_W'(1);
               if (count_ff == SEL_W'(CELL_COUNT - 1)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            // Chain restarts the current bin this cycle
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Register writes
   always_comb begin
      period_in    = period_ff;
      wrap_task_in = wrap_task_ff;
      if (csr_write_enable) begin
         case (csr_index)
            tmth_pkg::CSR_TIMER_PERIOD: period_in    = csr_write_data[TICK_W-1:0];
            tmth_pkg::CSR_WRAP_TASK:    wrap_task_in = csr_write_data[tmth_pkg::TASK_W-1:0];
            default: begin
               period_in = period_ff;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         mask_ff      <= '0;
         period_ff    <= PERIOD_RESET;
         wrap_task_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         mask_ff      <= mask_in;
         period_ff    <= period_in;
         wrap_task_ff <= wrap_task_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      task_ff      <= task_in;
      now_ff       <= now_in;
      addend_ff    <= addend_in;
      wrap_ff      <= wrap_in;
      count_ff     <= count_in;
      rsp_index_ff <= rsp_index_in;
      rsp_ticks_ff <= rsp_ticks_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.bin_index = rsp_index_ff;
   assign rsp.bin_ticks = rsp_ticks_ff;
   assign rsp.last      = rsp_last_ff;

endmodule

>>> src/tmth_checker.sv
`include "task_mask_time_histogram_assert.svh"

module tmth_checker #(
   parameter int BIN_COUNT = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tmth_pkg::BIN_IDX_W-1:0]   rsp_bin_index,
   input logic [tmth_pkg::TICK_W-1:0]      rsp_bin_ticks,
   input logic                             rsp_last
);

   // Stalled item holds
   `TMTH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bin_index) && $stable(rsp_bin_ticks) && $stable(rsp_last))

   // No new request taken while a report run is still streaming
   `TMTH_ASSERT_IMPLY(a_busy_in_run, clock, reset, rsp_valid && !rsp_last && (rsp_bin_index != 4'd15), !req_ready)

   // A taken bin is followed at once by the next bin
   `TMTH_ASSERT_NEXT(a_run_advance, clock, reset, rsp_valid && rsp_ready && !rsp_last && (rsp_bin_index != 4'd15), rsp_valid && (rsp_bin_index == 4'($past(rsp_bin_index) + 4'd1)))

   // Last only on the final bin
   `TMTH_ASSERT_IMPLY(a_last_index, clock, reset, rsp_valid && rsp_last, rsp_bin_index == 4'(BIN_COUNT - 1))

   // Nothing pending right after reset
   `TMTH_ASSERT_IMPLY(a_reset_quiet, clock, reset, $past(reset), !rsp_valid && (req_ready || !req_valid || req_ready))

endmodule

bind task_mask_time_histogram tmth_checker #(
   .BIN_COUNT (BIN_COUNT)
) u_tmth_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_bin_index (rsp.bin_index),
   .rsp_bin_ticks (rsp.bin_ticks),
   .rsp_last      (rsp.last)
);

>>> tb/task_mask_time_histogram_tb.sv
module task_mask_time_histogram_tb;

   localparam int TICK_W      = tmth_pkg::TICK_W;
   localparam int TASK_W      = tmth_pkg::TASK_W;
   localparam int MASK_W      = tmth_pkg::MASK_W;
   localparam int BIN_IDX_W   = tmth_pkg::BIN_IDX_W;
   localparam int CSR_INDEX_W = tmth_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = tmth_pkg::CSR_DATA_W;

   localparam int BINS          = 16;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 70;
   localparam int QUIET_CYCLES  = 32;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct packed {
      logic [BIN_IDX_W-1:0] index;
      logic [TICK_W-1:0]    ticks;
      logic                 last;
   } bin_report_type;

   // Tracks the tick histogram and holds the bin reports still owed by the block
   class histogram_tracker;
      logic [TICK_W-1:0] timer_period;
      logic [TASK_W-1:0] wrap_task;
      logic [TICK_W-1:0] previous_count;
      logic [MASK_W-1:0] active_mask;
      logic [TICK_W-1:0] tick_bins [BINS];
      bin_report_type    expected_bins [$];
      int                errors;

      function new();
         timer_period   = 32'd60000000;
         wrap_task      = '0;
         previous_count = '0;
         active_mask    = '0;
         foreach (tick_bins[i]) tick_bins[i] = '0;
         errors         = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == tmth_pkg::CSR_TIMER_PERIOD) timer_period = data;
         else if (index == tmth_pkg::CSR_WRAP_TASK) wrap_task = data[TASK_W-1:0];
      endfunction

      // Advance the histogram by one accepted item
      function void note_item(tmth_pkg::op_type op, logic [TASK_W-1:0] task_bit,
                              logic [TICK_W-1:0] count);
         logic [BIN_IDX_W-1:0] slot;
         bin_report_type       report;
         case (op)
            tmth_pkg::OP_MARK: begin
               active_mask[task_bit] = 1'b1;
            end
            tmth_pkg::OP_CLEAR: begin
               active_mask = '0;
            end
            tmth_pkg::OP_SAMPLE: begin
               if (previous_count != '0) begin
                  if (count < previous_count) begin
                     // wrap: close out the old period, then stream every bin
                     active_mask[wrap_task] = 1'b1;
                     slot = active_mask;
                     tick_bins[slot] = tick_bins[slot] + (timer_period - previous_count);
                     for (int i = 0; i < BINS; i++) begin
                        report.index = BIN_IDX_W'(i);
                        report.ticks = tick_bins[i];
                        report.last  = (i == BINS - 1);
                        expected_bins.push_back(report);
                        tick_bins[i] = '0;
                     end
                     tick_bins[slot] = count;
                  end else begin
                     slot = active_mask;
                     tick_bins[slot] = tick_bins[slot] + (count - previous_count);
                  end
               end
               previous_count = count;
            end
            default: begin
            end
         endcase
      endfunction

      function void report_mismatch(string field, logic [TICK_W-1:0] want,
                                    logic [TICK_W-1:0] got);
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         errors++;
      endfunction

      // Compare one bin item from the block with the oldest owed report
      function void check_bin(logic [BIN_IDX_W-1:0] index, logic [TICK_W-1:0] ticks,
                              logic last);
         bin_report_type want;
         if (expected_bins.size() == 0) begin
            $display("%0t: bin item: expected none, actual index %0d ticks %0d last %0b",
                     $time, index, ticks, last);
            errors++;
            return;
         end
         want = expected_bins.pop_front();
         if (index !== want.index) report_mismatch("bin_index", want.index, index);
         if (ticks !== want.ticks) report_mismatch("bin_ticks", want.ticks, ticks);
         if (last !== want.last) report_mismatch("last", want.last, last);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   tmth_req_if req_ch ();
   tmth_rsp_if rsp_ch ();

   histogram_tracker tracker = new();

   bit idle_enable  = 1'b1;
   bit hold_request = 1'b0;
   int items_sent   = 0;

   task_mask_time_histogram dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Result side: check each bin item, stall in bursts or in one long hold
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            tracker.check_bin(rsp_ch.bin_index, rsp_ch.bin_ticks, rsp_ch.last);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Offer one item, maybe after an idle burst, and hold it until accepted
   task automatic send_item(tmth_pkg::op_type op, logic [TASK_W-1:0] task_bit,
                            logic [TICK_W-1:0] count);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.task_req    <= task_bit;
      req_ch.timer_count <= count;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_item(op, task_bit, count);
      items_sent++;
   endtask

   // Stop offering and wait for every owed bin, then let the block settle
   task automatic drain(int quiet_cycles);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (tracker.expected_bins.size() != 0);
      repeat (quiet_cycles) @(posedge clock);
   endtask

   task automatic configure(logic [TICK_W-1:0] period, logic [TASK_W-1:0] wrap_bit);
      csr_write_enable <= 1'b1;
      csr_index        <= tmth_pkg::CSR_TIMER_PERIOD;
      csr_write_data   <= period;
      @(posedge clock);
      tracker.write_register(tmth_pkg::CSR_TIMER_PERIOD, period);
      csr_index        <= tmth_pkg::CSR_WRAP_TASK;
      csr_write_data   <= CSR_DATA_W'(wrap_bit);
      @(posedge clock);
      tracker.write_register(tmth_pkg::CSR_WRAP_TASK, CSR_DATA_W'(wrap_bit));
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [TICK_W-1:0] later_count(logic [TICK_W-1:0] now);
      logic [TICK_W-1:0] headroom;
      logic [TICK_W-1:0] step;
      headroom = 32'hFFFF_FFFF - now;
      case ($urandom_range(0, 3))
         0:       step = $urandom_range(0, 1000);
         1:       step = $urandom_range(0, 1 << 20);
         2:       step = $urandom;
         default: step = $urandom_range(1, 100);
      endcase
      if (step > headroom) step = headroom;
      return now + step;
   endfunction

   // One timer period: a first sample, rising samples among task changes, then a wrap
   task automatic run_period();
      logic [TICK_W-1:0] now;
      case ($urandom_range(0, 9))
         0:       now = '0;
         1, 2:    now = $urandom;
         default: now = $urandom_range(1, 50000);
      endcase
      send_item(tmth_pkg::OP_SAMPLE, TASK_W'($urandom_range(0, 3)), now);
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 2) == 0)
            send_item(tmth_pkg::OP_MARK, TASK_W'($urandom_range(0, 3)), $urandom);
         if ($urandom_range(0, 9) == 0)
            send_item(tmth_pkg::OP_CLEAR, TASK_W'($urandom_range(0, 3)), $urandom);
         now = later_count(now);
         send_item(tmth_pkg::OP_SAMPLE, TASK_W'($urandom_range(0, 3)), now);
      end
      if (now != '0)
         send_item(tmth_pkg::OP_SAMPLE, TASK_W'($urandom_range(0, 3)),
                   ($urandom_range(0, 4) == 0) ? '0 : $urandom_range(0, now - 1));
   endtask

   initial begin
      int phase_start;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= tmth_pkg::OP_MARK;
      req_ch.task_req  <= '0;
      req_ch.timer_count <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= tmth_pkg::CSR_TIMER_PERIOD;
      csr_write_data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero count as no prior sample, every task bit, ignored code,
      // period below the previous count, zero-length interval, wrap to zero
      send_item(tmth_pkg::OP_SAMPLE, 2'd0, 32'd0);
      send_item(tmth_pkg::OP_SAMPLE, 2'd1, 32'd100);
      send_item(tmth_pkg::OP_MARK, 2'd0, 32'd0);
      send_item(tmth_pkg::OP_MARK, 2'd1, 32'd0);
      send_item(tmth_pkg::OP_MARK, 2'd2, 32'd0);
      send_item(tmth_pkg::OP_MARK, 2'd3, 32'hFFFF_FFFF);
      send_item(tmth_pkg::OP_UNUSED, 2'd3, 32'hFFFF_FFFF);
      send_item(tmth_pkg::OP_SAMPLE, 2'd3, 32'hFFFF_FFFF);
      send_item(tmth_pkg::OP_CLEAR, 2'd3, 32'hFFFF_FFFF);
      send_item(tmth_pkg::OP_SAMPLE, 2'd0, 32'd5);
      send_item(tmth_pkg::OP_MARK, 2'd2, 32'd0);
      send_item(tmth_pkg::OP_SAMPLE, 2'd0, 32'd10);
      send_item(tmth_pkg::OP_SAMPLE, 2'd0, 32'd10);
      send_item(tmth_pkg::OP_SAMPLE, 2'd0, 32'd0);
      send_item(tmth_pkg::OP_SAMPLE, 2'd0, 32'd3);
      send_item(tmth_pkg::OP_SAMPLE, 2'd0, 32'd2);
      send_item(tmth_pkg::OP_CLEAR, 2'd0, 32'd0);
      send_item(tmth_pkg::OP_SAMPLE, 2'd0, 32'h8000_0000);
      send_item(tmth_pkg::OP_SAMPLE, 2'd0, 32'hFFFF_FFFF);
      send_item(tmth_pkg::OP_SAMPLE, 2'd0, 32'd1);
      send_item(tmth_pkg::OP_UNUSED, 2'd0, 32'd0);

      // Random phases, each under its own register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         drain(QUIET_CYCLES);
         case (phase)
            0:       configure(32'd1, 2'd3);
            1:       configure(32'hFFFF_FFFF, 2'd1);
            2:       configure($urandom_range(1, 32'hFFFF_FFFF), 2'd2);
            3:       configure(32'd1000, 2'd0);
            4:       configure($urandom_range(1, 100000), TASK_W'($urandom_range(0, 3)));
            default: configure($urandom_range(1, 32'hFFFF_FFFF), TASK_W'($urandom_range(0, 3)));
         endcase
         if (phase == 2) hold_request = 1'b1;
         if (phase == PHASES - 1) idle_enable = 1'b0;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if (phase == 3 && items_sent - phase_start > PHASE_ITEMS / 2
                && tracker.expected_bins.size() != 0)
               drain(0);
            if ($urandom_range(0, 9) < 8) begin
               run_period();
            end else begin
               // noise: any code, any fields
               repeat ($urandom_range(1, 4))
                  send_item(tmth_pkg::op_type'($urandom_range(0, 3)),
                            TASK_W'($urandom_range(0, 3)), $urandom);
            end
         end
      end

      drain(QUIET_CYCLES);
      if (tracker.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
